@@ rtl/pcts_pkg.sv @@
// Shared types and constants for the POV column timing scheduler.
package pcts_pkg;

  // Divisor is speed (20 bits) times column count (8 bits).
  localparam int unsigned SPEED_W = 20;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned DIVR_W  = SPEED_W + COUNT_W;

  localparam logic [15:0]        PERIOD_MAX   = 16'd65000;
  localparam logic [15:0]        PERIOD_MIN   = 16'd1;
  localparam logic [SPEED_W-1:0] SPEED_MIN    = 20'd2;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = 8'd64;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        timer_now;
    logic               speed_ready;
    logic [SPEED_W-1:0] speed_rpm_q4;
  } in_item_t;

  typedef struct packed {
    logic               flash;
    logic [COUNT_W-1:0] column_index;
    logic [15:0]        period_ticks;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/pcts_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module pcts_div #(
  parameter int unsigned NUM_W = 28
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          dividend,
  input  logic [pcts_pkg::DIVR_W-1:0] divisor,
  output pcts_pkg::div_stat_t       stat,
  output logic [NUM_W-1:0]          quotient
);

  localparam int unsigned DW    = pcts_pkg::DIVR_W;
  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;
  logic [NUM_W:0]   quo_shift;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial     = {rem_r, quo_r[NUM_W-1]};
    ge        = trial >= {1'b0, dvs_r};
    diff      = trial - {1'b0, dvs_r};
    rem_nxt   = ge ? diff[DW-1:0] : trial[DW-1:0];
    quo_shift = {quo_r, ge};
    quo_nxt   = quo_shift[NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ rtl/pov_column_timing_scheduler.sv @@
// Top level of the POV column timing scheduler: sequencer, state and I/O registers.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one transaction per
//   poll, start or stop command. Every accepted transaction yields exactly one
//   result transaction on the output channel (out_valid / out_stall / out_data):
//   flash flag, flashed column and the current ticks-per-column period.
//   cfg_we / cfg_wdata write the column count; write it only while idle.
//   Start, stop, ignored ops and non-dividing polls pass from the check step
//   straight to the write-back step into the output register. A poll with
//   a ready, valid speed runs the divider, which yields the NUM_W quotient bits
//   one at a time (NUM_W = bits of TICK_NUMERATOR, 28 by default), then the
//   clamp, flash and write-back steps; write-back also waits out any output stall.
//   One transaction is in flight at a time; in_stall is high while the
//   sequencer is busy. A result waiting in the output register does not block
//   acceptance; only the final write-back step waits for it to drain.
//   Reset (synchronous, rst_n low): display disabled, period, deadline and
//   column position cleared, column count back to 64, output register empty.
//   A stalled result holds in the output register unchanged until taken.
module pov_column_timing_scheduler #(
  parameter longint unsigned TICK_NUMERATOR = 240000000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcts_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcts_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [pcts_pkg::COUNT_W-1:0]        cfg_wdata
);

  localparam int unsigned NUM_W = $clog2(TICK_NUMERATOR + 1);
  localparam logic [NUM_W-1:0] NUM_VAL = NUM_W'(TICK_NUMERATOR);
  localparam int unsigned CW = pcts_pkg::COUNT_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHK   = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_CLAMP = 6'b001000,
    ST_FLASH = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Latched transaction and block state.
  pcts_pkg::in_item_t item_r;
  logic [CW-1:0] cfg_count_r;
  logic [CW-1:0] col_pos_r;
  logic [15:0]   period_r;
  logic [15:0]   deadline_r;
  logic          started_r;
  logic          enabled_r;
  logic          flash_r;
  logic [CW-1:0] col_out_r;

  logic                 out_valid_r;
  pcts_pkg::out_item_t  out_data_r;

  // Divider hookup.
  logic                          div_start;
  logic [pcts_pkg::DIVR_W-1:0]   div_divisor;
  pcts_pkg::div_stat_t           div_stat;
  logic [NUM_W-1:0]              div_quo;

  logic          poll_go;
  logic          speed_ok;
  logic [63:0]   quo_ext;
  logic [15:0]   period_clamped;
  logic [15:0]   elapsed;
  logic          due;
  logic [CW-1:0] col_inc;
  logic          out_load;

  assign in_stall = (state_r != ST_IDLE);

  // A poll only acts while enabled and with a ready speed.
  assign poll_go  = (item_r.op == pcts_pkg::OP_POLL) && enabled_r && item_r.speed_ready;
  assign speed_ok = (cfg_count_r != '0) && (item_r.speed_rpm_q4 >= pcts_pkg::SPEED_MIN);

  // Single 20x8 multiply, registered inside the divider at start.
  assign div_start   = (state_r == ST_CHK) && poll_go && speed_ok;
  assign div_divisor = pcts_pkg::DIVR_W'(item_r.speed_rpm_q4 * cfg_count_r);

  pcts_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (NUM_VAL),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Clamp the quotient to 1..65000.
  always_comb begin
    quo_ext = 64'(div_quo);
    if (quo_ext > 64'(pcts_pkg::PERIOD_MAX)) begin
      period_clamped = pcts_pkg::PERIOD_MAX;
    end else if (quo_ext < 64'(pcts_pkg::PERIOD_MIN)) begin
      period_clamped = pcts_pkg::PERIOD_MIN;
    end else begin
      period_clamped = quo_ext[15:0];
    end
  end

  // Wrapped elapsed time since the deadline; advance column with 8-bit wrap.
  assign elapsed = item_r.timer_now - deadline_r;
  assign due     = elapsed >= period_r;
  assign col_inc = col_pos_r + 1'b1;

  // Write back only once the output register is free or draining.
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHK;
      ST_CHK:   state_nxt = div_start ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_stat.done) state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_FLASH;
      ST_FLASH: state_nxt = ST_FIN;
      ST_FIN:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_count_r <= pcts_pkg::COUNT_RESET;
      col_pos_r   <= '0;
      period_r    <= '0;
      deadline_r  <= '0;
      started_r   <= 1'b0;
      enabled_r   <= 1'b0;
      flash_r     <= 1'b0;
      col_out_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_count_r <= cfg_wdata;
      end

      unique case (state_r)
        ST_IDLE: begin
          flash_r   <= 1'b0;
          col_out_r <= '0;
        end
        ST_CHK: begin
          priority if (item_r.op == pcts_pkg::OP_START) begin
            enabled_r <= 1'b1;
            started_r <= 1'b0;
          end else if (item_r.op == pcts_pkg::OP_STOP) begin
            enabled_r <= 1'b0;
            started_r <= 1'b0;
            period_r  <= '0;
          end else if (poll_go && !speed_ok) begin
            period_r <= '0;
          end else begin
          end
        end
        ST_DIV: begin
        end
        ST_CLAMP: begin
          // Store the clamped period; latch the start time on the first valid poll after a start.
          period_r <= period_clamped;
          if (!started_r) begin
            started_r  <= 1'b1;
            deadline_r <= item_r.timer_now;
          end
        end
        ST_FLASH: begin
          if (due) begin
            flash_r    <= 1'b1;
            col_out_r  <= col_pos_r;
            col_pos_r  <= (col_inc >= cfg_count_r) ? '0 : col_inc;
            deadline_r <= deadline_r + period_r;
          end
        end
        ST_FIN: begin
        end
        default: begin
        end
      endcase

      // Hold the result until taken; refill in the same cycle it drains.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_data_r.flash        <= flash_r;
      out_data_r.column_index <= col_out_r;
      out_data_r.period_ticks <= period_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // No transaction is accepted while the divider is working.
  a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !div_stat.busy)
    else $error("input accepted while divider busy");

  // A new result appears only from the write-back step.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result produced outside write-back");

  // The period never exceeds the clamp limit.
  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    period_r <= pcts_pkg::PERIOD_MAX)
    else $error("period above clamp limit");

  // After a flash the column position is inside the column count.
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLASH && due && !cfg_we) |=> (col_pos_r < cfg_count_r || col_pos_r == '0))
    else $error("column position out of range after flash");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the POV column timing scheduler.
`timescale 1ns / 1ps

module testbench;

  // Tick budget per revolution: 60 s / 4 us per tick, with the speed in RPM x 16.
  localparam longint unsigned TICKS_PER_REV = 240000000;
  // Op code with no meaning: the block ignores it and only reports the period.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Margin that covers the longest transaction (a dividing poll).
  localparam int SETTLE_CYCLES = 40;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 130;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pcts_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pcts_pkg::out_item_t  out_data;
  logic                 cfg_we = 1'b0;
  logic [pcts_pkg::COUNT_W-1:0] cfg_wdata = '0;

  pov_column_timing_scheduler #(
    .TICK_NUMERATOR(TICKS_PER_REV)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Column timing predictor: a private copy of the scheduler state.
  // ---------------------------------------------------------------------------
  logic [pcts_pkg::COUNT_W-1:0] col_count = pcts_pkg::COUNT_RESET;
  logic [pcts_pkg::COUNT_W-1:0] col_pos = '0;
  logic [15:0]        col_period = '0;
  logic [15:0]        next_deadline = '0;
  logic               deadline_latched = 1'b0;
  logic               display_on = 1'b0;

  // Results still owed by the block, oldest first.
  pcts_pkg::out_item_t column_results_q[$];

  // Knobs of the current idling phase, in percent.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  bit failed = 1'b0;

  // Advance the predicted state by one transaction and return its result.
  function automatic pcts_pkg::out_item_t predict_column(input pcts_pkg::in_item_t it);
    pcts_pkg::out_item_t r;
    longint unsigned  divisor;
    longint unsigned  quotient;
    logic [15:0]      elapsed;
    r = '0;
    if (it.op == pcts_pkg::OP_START) begin
      display_on = 1'b1;
      deadline_latched = 1'b0;
    end else if (it.op == pcts_pkg::OP_STOP) begin
      display_on = 1'b0;
      deadline_latched = 1'b0;
      col_period = '0;
    end else if (it.op == pcts_pkg::OP_POLL && display_on && it.speed_ready) begin
      if (col_count != 0 && it.speed_rpm_q4 >= pcts_pkg::SPEED_MIN) begin
        divisor = it.speed_rpm_q4;
        divisor = divisor * col_count;
        quotient = TICKS_PER_REV / divisor;
        // Clamp the ticks-per-column into the representable window.
        if (quotient < pcts_pkg::PERIOD_MIN) quotient = pcts_pkg::PERIOD_MIN;
        if (quotient > pcts_pkg::PERIOD_MAX) quotient = pcts_pkg::PERIOD_MAX;
        col_period = quotient[15:0];
        // First good poll after a start anchors the schedule at "now".
        if (!deadline_latched) begin
          deadline_latched = 1'b1;
          next_deadline = it.timer_now;
        end
        // Elapsed time is modulo 2^16 since the timer wraps.
        elapsed = it.timer_now - next_deadline;
        if (elapsed >= col_period) begin
          r.flash = 1'b1;
          r.column_index = col_pos;
          // Wrap on the 8-bit increment first, then against the column count,
          // so a count lowered below the position still lands back on zero.
          col_pos = col_pos + 1'b1;
          if (col_pos >= col_count) col_pos = '0;
          next_deadline = next_deadline + col_period;
        end
      end else begin
        col_period = '0;
      end
    end
    r.period_ticks = col_period;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation for the random part.
  // ---------------------------------------------------------------------------
  logic [pcts_pkg::SPEED_W-1:0] spin_speed = 20'd48000;
  logic [15:0]        rotor_stamp = '0;

  // Mostly well-formed polls on a timer that advances around one period, so
  // the schedule flashes regularly; the rest is starts, stops, ignored ops,
  // not-ready polls and fully random transactions.
  function automatic pcts_pkg::in_item_t make_random_item();
    pcts_pkg::in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0)
      spin_speed = pcts_pkg::SPEED_W'($urandom_range(2, 20'hFFFFF) >> $urandom_range(0, 19));
    rotor_stamp = rotor_stamp + 16'($urandom_range(0, 2 * col_period + 3));
    it.op = pcts_pkg::OP_POLL;
    it.timer_now = rotor_stamp;
    it.speed_ready = 1'b1;
    it.speed_rpm_q4 = spin_speed;
    if (pick < 4) begin
      it.op = pcts_pkg::OP_START;
    end else if (pick < 5) begin
      it.op = pcts_pkg::OP_STOP;
    end else if (pick < 7) begin
      it.op = OP_UNUSED;
    end else if (pick < 10) begin
      it.speed_ready = 1'b0;
    end else if (pick < 16) begin
      it.op = 2'($urandom_range(0, 3));
      it.timer_now = 16'($urandom);
      it.speed_ready = 1'($urandom);
      it.speed_rpm_q4 = pcts_pkg::SPEED_W'($urandom);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: a row is either a column count write or a transaction,
  // the latter optionally carrying a hand-typed expected result.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                           wr_count;
    logic [pcts_pkg::COUNT_W-1:0] count_val;
    pcts_pkg::in_item_t           item;
    bit                           typed;
    pcts_pkg::out_item_t          want;
  } script_row_t;

  script_row_t script[$];

  function automatic void row_poll(input logic [1:0] op, input logic [15:0] stamp,
                                   input logic rdy,
                                   input logic [pcts_pkg::SPEED_W-1:0] spd);
    script_row_t row;
    row = '{default: '0};
    row.item = '{op: op, timer_now: stamp, speed_ready: rdy, speed_rpm_q4: spd};
    script.push_back(row);
  endfunction

  function automatic void row_known(input logic [1:0] op, input logic [15:0] stamp,
                                    input logic rdy,
                                    input logic [pcts_pkg::SPEED_W-1:0] spd,
                                    input logic fl,
                                    input logic [pcts_pkg::COUNT_W-1:0] col,
                                    input logic [15:0] per);
    row_poll(op, stamp, rdy, spd);
    script[$].typed = 1'b1;
    script[$].want = '{flash: fl, column_index: col, period_ticks: per};
  endfunction

  function automatic void row_count(input logic [pcts_pkg::COUNT_W-1:0] v);
    script_row_t row;
    row = '{default: '0};
    row.wr_count = 1'b1;
    row.count_val = v;
    script.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side driver.
  // ---------------------------------------------------------------------------
  // Hold the transaction until accepted, log its expectation, then idle at random.
  task automatic send_item(input pcts_pkg::in_item_t it, input bit typed,
                           input pcts_pkg::out_item_t want);
    pcts_pkg::out_item_t pred;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_column(it);
    column_results_q.push_back(typed ? want : pred);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Block until every owed result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (column_results_q.size() != 0) @(posedge clk);
  endtask

  // Write the column count only once the block is quiet.
  task automatic load_column_count(input logic [pcts_pkg::COUNT_W-1:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    col_count = v;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, result checking, hang watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    pcts_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (column_results_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        failed = 1'b1;
      end else begin
        want = column_results_q.pop_front();
        if (out_data.flash !== want.flash) begin
          $display("%0t: flash expected %0d, got %0d", $time, want.flash, out_data.flash);
          failed = 1'b1;
        end
        if (out_data.column_index !== want.column_index) begin
          $display("%0t: column_index expected %0d, got %0d", $time,
                   want.column_index, out_data.column_index);
          failed = 1'b1;
        end
        if (out_data.period_ticks !== want.period_ticks) begin
          $display("%0t: period_ticks expected %0d, got %0d", $time,
                   want.period_ticks, out_data.period_ticks);
          failed = 1'b1;
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  logic [pcts_pkg::COUNT_W-1:0] phase_counts[8];

  initial begin
    // Poll while disabled, ignored op and stop all leave the reset state alone.
    row_known(pcts_pkg::OP_POLL, 16'd0, 1'b1, 20'd1000, 1'b0, 8'd0, 16'd0);
    row_known(OP_UNUSED, 16'hFFFF, 1'b1, 20'hFFFFF, 1'b0, 8'd0, 16'd0);
    row_known(pcts_pkg::OP_STOP, 16'd0, 1'b0, 20'd0, 1'b0, 8'd0, 16'd0);
    row_known(pcts_pkg::OP_START, 16'd0, 1'b0, 20'd0, 1'b0, 8'd0, 16'd0);
    // Speed not ready, zero speed and speed one: no period.
    row_known(pcts_pkg::OP_POLL, 16'd50, 1'b0, 20'd500, 1'b0, 8'd0, 16'd0);
    row_known(pcts_pkg::OP_POLL, 16'd60, 1'b1, 20'd0, 1'b0, 8'd0, 16'd0);
    row_known(pcts_pkg::OP_POLL, 16'd70, 1'b1, 20'd1, 1'b0, 8'd0, 16'd0);
    // Slowest valid speed clamps to the maximum period; anchors the deadline.
    row_known(pcts_pkg::OP_POLL, 16'd100, 1'b1, 20'd2, 1'b0, 8'd0, pcts_pkg::PERIOD_MAX);
    // Fastest speed: short period, flashes, then a poll across the timer wrap.
    row_poll(pcts_pkg::OP_POLL, 16'd100, 1'b1, 20'hFFFFF);
    row_poll(pcts_pkg::OP_POLL, 16'd103, 1'b1, 20'hFFFFF);
    row_poll(pcts_pkg::OP_POLL, 16'hFFFF, 1'b1, 20'hFFFFF);
    row_poll(OP_UNUSED, 16'd0, 1'b0, 20'd0);
    row_poll(pcts_pkg::OP_POLL, 16'd200, 1'b1, 20'd48000);
    row_poll(pcts_pkg::OP_POLL, 16'd300, 1'b1, 20'd48000);
    // Widest count with the fastest speed clamps the period to the minimum.
    row_count(8'd255);
    row_poll(pcts_pkg::OP_START, 16'd0, 1'b0, 20'd0);
    row_known(pcts_pkg::OP_POLL, 16'd5, 1'b1, 20'hFFFFF, 1'b0, 8'd0, pcts_pkg::PERIOD_MIN);
    row_poll(pcts_pkg::OP_POLL, 16'd6, 1'b1, 20'hFFFFF);
    row_poll(pcts_pkg::OP_POLL, 16'd7, 1'b1, 20'hFFFFF);
    row_poll(pcts_pkg::OP_POLL, 16'd8, 1'b1, 20'hFFFFF);
    row_poll(pcts_pkg::OP_POLL, 16'd9, 1'b1, 20'hFFFFF);
    // Zero columns: period drops to zero.
    row_count(8'd0);
    row_known(pcts_pkg::OP_POLL, 16'd9, 1'b1, 20'd1000, 1'b0, 8'd0, 16'd0);
    // Count lowered below the current position: next flash wraps to zero.
    row_count(8'd2);
    row_poll(pcts_pkg::OP_POLL, 16'd509, 1'b1, 20'hFFFFF);
    row_poll(pcts_pkg::OP_POLL, 16'd1000, 1'b1, 20'hFFFFF);
    row_known(pcts_pkg::OP_STOP, 16'd1000, 1'b1, 20'hFFFFF, 1'b0, 8'd0, 16'd0);

    phase_counts = '{8'd64, 8'd255, 8'd1, 8'd0, 8'd2, 8'd128, 8'd0, 8'd200};
    phase_counts[6] = pcts_pkg::COUNT_W'($urandom_range(3, 254));

    // Hold reset, then release it for good.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table with no idling on either side.
    set_idling(0);
    foreach (script[i]) begin
      if (script[i].wr_count) load_column_count(script[i].count_val);
      else send_item(script[i].item, script[i].typed, script[i].want);
    end

    // Random phases: each sets a column count, an idling mode and restarts
    // the display, then runs mostly well-formed polls.
    for (int p = 0; p < 8; p++) begin
      load_column_count(phase_counts[p]);
      set_idling(p % 4);
      send_item('{op: pcts_pkg::OP_START, timer_now: rotor_stamp, speed_ready: 1'b0,
                  speed_rpm_q4: '0}, 1'b0, '0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through, hold the sender until the block has caught up.
        if (n == PHASE_ITEMS / 2) drain_results();
        send_item(make_random_item(), 1'b0, '0);
      end
    end

    // Drop valid, wait out every owed result, then let the pipeline settle.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pcts_pkg.sv
rtl/pcts_div.sv
rtl/pov_column_timing_scheduler.sv
tb/testbench.sv
